// ----- rtl/stream_min_max_mean_variance_core_defines.svh -----
// Assertion macros shared by the stream statistics RTL.
// Every macro expects clk and rst_n to be visible in the module that uses it.
`ifndef STREAM_MIN_MAX_MEAN_VARIANCE_CORE_DEFINES_SVH
`define STREAM_MIN_MAX_MEAN_VARIANCE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMMV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMMV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/smmv_pkg.sv -----
// Package for the stream statistics core: queue depth, queue status type, sequencer states.
// No dependencies.
package smmv_pkg;

    // Depth of the queue between the accumulator and the arithmetic unit.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_M,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_DIV_V,
        ST_OUT
    } back_state_t;

endpackage

// ----- rtl/smmv_front.sv -----
// Accumulator front end: count, sum, sum of squares, min and max per set.
// Depends on smmv_pkg for the queue status type.
module smmv_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic                                  last,
    input  smmv_pkg::qstat_t                      q_stat,
    output logic                                  q_push,
    output logic signed [SAMPLE_BITS-1:0]         rec_max,
    output logic [COUNT_BITS-1:0]                 rec_max_idx,
    output logic signed [SAMPLE_BITS-1:0]         rec_min,
    output logic [COUNT_BITS-1:0]                 rec_min_idx,
    output logic [COUNT_BITS:0]                   rec_count,
    output logic signed [SAMPLE_BITS+COUNT_BITS:0] rec_sum,
    output logic [2*SAMPLE_BITS+COUNT_BITS:0]     rec_sq,
    output logic                                  rec_drop
);
    import smmv_pkg::*;

    localparam int SW   = SAMPLE_BITS;
    localparam int CW   = COUNT_BITS;
    localparam int NW   = CW + 1;
    localparam int SUMW = SW + CW + 1;
    localparam int SQW  = 2 * SW + CW + 1;

    localparam logic signed [SW-1:0] MOST_NEG = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] MOST_POS = {1'b0, {(SW-1){1'b1}}};

    logic [NW-1:0]          cnt_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [SQW-1:0]         sq_reg;
    logic signed [SW-1:0]   max_reg;
    logic [CW-1:0]          max_idx_reg;
    logic signed [SW-1:0]   min_reg;
    logic [CW-1:0]          min_idx_reg;
    logic                   drop_reg;

    logic                   accept;
    logic                   at_cap;
    logic signed [2*SW-1:0] square;

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;
    assign at_cap = cnt_reg[CW];
    assign square = sample * sample;
    assign q_push = accept && last;

    // Values after this sample, pushed as the set's record when it is the last one.
    always_comb
    begin
        rec_max     = max_reg;
        rec_max_idx = max_idx_reg;
        rec_min     = min_reg;
        rec_min_idx = min_idx_reg;
        rec_count   = cnt_reg;
        rec_sum     = sum_reg;
        rec_sq      = sq_reg;
        rec_drop    = drop_reg;
        if (at_cap)
        begin
            rec_drop = 1'b1;
        end
        else
        begin
            if (sample > max_reg)
            begin
                rec_max     = sample;
                rec_max_idx = cnt_reg[CW-1:0];
            end
            if (sample < min_reg)
            begin
                rec_min     = sample;
                rec_min_idx = cnt_reg[CW-1:0];
            end
            rec_sum   = sum_reg + {{(SUMW-SW){sample[SW-1]}}, sample};
            rec_sq    = sq_reg + {{(SQW-2*SW){1'b0}}, square};
            rec_count = cnt_reg + NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            max_reg     <= MOST_NEG;
            max_idx_reg <= '0;
            min_reg     <= MOST_POS;
            min_idx_reg <= '0;
            drop_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                cnt_reg     <= '0;
                sum_reg     <= '0;
                sq_reg      <= '0;
                max_reg     <= MOST_NEG;
                max_idx_reg <= '0;
                min_reg     <= MOST_POS;
                min_idx_reg <= '0;
                drop_reg    <= 1'b0;
            end
            else
            begin
                cnt_reg     <= rec_count;
                sum_reg     <= rec_sum;
                sq_reg      <= rec_sq;
                max_reg     <= rec_max;
                max_idx_reg <= rec_max_idx;
                min_reg     <= rec_min;
                min_idx_reg <= rec_min_idx;
                drop_reg    <= rec_drop;
            end
        end
    end

endmodule

// ----- rtl/smmv_queue.sv -----
// Short queue carrying finished set records from the front end to the arithmetic unit.
// Depends on smmv_pkg and the assertion macro header.
`include "stream_min_max_mean_variance_core_defines.svh"

module smmv_queue #(
    parameter int WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    wdata,
    input  logic                pop,
    output logic [WIDTH-1:0]    rdata,
    output smmv_pkg::qstat_t    stat
);
    import smmv_pkg::*;

    localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTRW-1:0]  wptr_reg;
    logic [PTRW-1:0]  rptr_reg;
    logic [CNTW-1:0]  count_reg;

    logic do_push;
    logic do_pop;

    assign stat.full  = (count_reg == CNTW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem_reg[rptr_reg];

    function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
        ptr_inc = (p == PTRW'(QUEUE_DEPTH - 1)) ? '0 : p + PTRW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= ptr_inc(wptr_reg);
            end
            if (do_pop)
            begin
                rptr_reg <= ptr_inc(rptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

    `SMMV_ASSERT_NOW(a_no_push_full, push, !stat.full, "record pushed into a full queue")
    `SMMV_ASSERT_NOW(a_no_pop_empty, pop, !stat.empty, "record popped from an empty queue")
    `SMMV_ASSERT_NEXT(a_fill_up, do_push && !do_pop, count_reg == $past(count_reg) + CNTW'(1),
        "queue fill level did not rise on push")

endmodule

// ----- rtl/smmv_back.sv -----
// Arithmetic back end: shared shift-add multiplier and restoring divider that turn
// one set record into mean and variance, plus the result holding register.
// Depends on smmv_pkg and the assertion macro header.
`include "stream_min_max_mean_variance_core_defines.svh"

module smmv_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  smmv_pkg::qstat_t                        q_stat,
    output logic                                    q_pop,
    input  logic signed [SAMPLE_BITS-1:0]           rec_max,
    input  logic [COUNT_BITS-1:0]                   rec_max_idx,
    input  logic signed [SAMPLE_BITS-1:0]           rec_min,
    input  logic [COUNT_BITS-1:0]                   rec_min_idx,
    input  logic [COUNT_BITS:0]                     rec_count,
    input  logic signed [SAMPLE_BITS+COUNT_BITS:0]  rec_sum,
    input  logic [2*SAMPLE_BITS+COUNT_BITS:0]       rec_sq,
    input  logic                                    rec_drop,
    output logic                                    empty,
    input  logic                                    pop,
    output logic signed [SAMPLE_BITS-1:0]           max_value,
    output logic [COUNT_BITS-1:0]                   max_index,
    output logic signed [SAMPLE_BITS-1:0]           min_value,
    output logic [COUNT_BITS-1:0]                   min_index,
    output logic [COUNT_BITS:0]                     sample_count,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] mean_scaled,
    output logic [2*SAMPLE_BITS+FRAC_BITS-2:0]      variance_scaled,
    output logic                                    overflowed
);
    import smmv_pkg::*;

    localparam int SW    = SAMPLE_BITS;
    localparam int CW    = COUNT_BITS;
    localparam int F     = FRAC_BITS;
    localparam int NW    = CW + 1;
    localparam int SUMW  = SW + CW + 1;
    localparam int SQW   = 2 * SW + CW + 1;
    localparam int MAGW  = SW + CW;
    localparam int PW    = NW + SQW;
    localparam int DVW   = PW + F;
    localparam int DSW   = 2 * NW;
    localparam int REMW  = DSW + 1;
    localparam int MEANW = SW + F;
    localparam int VARW  = 2 * SW - 1 + F;
    localparam int QW    = VARW;
    localparam int STEPW = $clog2(DVW + 1);

    back_state_t state_reg, state_next;

    // Set record held while it is worked on.
    logic signed [SW-1:0] max_reg, max_next;
    logic [CW-1:0]        max_idx_reg, max_idx_next;
    logic signed [SW-1:0] min_reg, min_next;
    logic [CW-1:0]        min_idx_reg, min_idx_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [SQW-1:0]       sq_reg, sq_next;
    logic [MAGW-1:0]      mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic                 drop_reg, drop_next;

    // Shared arithmetic.
    logic [STEPW-1:0]     step_reg, step_next;
    logic [PW-1:0]        mcand_reg, mcand_next;
    logic [MAGW-1:0]      mplier_reg, mplier_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [PW-1:0]        dvar_reg, dvar_next;
    logic [DVW-1:0]       dvd_reg, dvd_next;
    logic [DSW-1:0]       dsr_reg, dsr_next;
    logic [REMW-1:0]      rem_reg, rem_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [MEANW-1:0]     mean_reg, mean_next;

    // Result holding register.
    logic                 ov_reg, ov_next;
    logic signed [SW-1:0] out_max_reg, out_max_next;
    logic [CW-1:0]        out_max_idx_reg, out_max_idx_next;
    logic signed [SW-1:0] out_min_reg, out_min_next;
    logic [CW-1:0]        out_min_idx_reg, out_min_idx_next;
    logic [NW-1:0]        out_n_reg, out_n_next;
    logic [MEANW-1:0]     out_mean_reg, out_mean_next;
    logic [VARW-1:0]      out_var_reg, out_var_next;
    logic                 out_drop_reg, out_drop_next;

    // One step of each shared unit.
    logic [PW-1:0]        prod_s;
    logic [REMW-1:0]      trial;
    logic                 ge;
    logic [REMW-1:0]      rem_s;
    logic [QW-1:0]        quo_s;
    logic [SUMW-1:0]      sum_abs;

    assign prod_s  = mplier_reg[0] ? prod_reg + mcand_reg : prod_reg;
    assign trial   = {rem_reg[REMW-2:0], dvd_reg[DVW-1]};
    assign ge      = (trial >= REMW'(dsr_reg));
    assign rem_s   = ge ? trial - REMW'(dsr_reg) : trial;
    assign quo_s   = {quo_reg[QW-2:0], ge};
    assign sum_abs = rec_sum[SUMW-1] ? SUMW'(0) - rec_sum : rec_sum;

    assign empty           = !ov_reg;
    assign max_value       = out_max_reg;
    assign max_index       = out_max_idx_reg;
    assign min_value       = out_min_reg;
    assign min_index       = out_min_idx_reg;
    assign sample_count    = out_n_reg;
    assign mean_scaled     = out_mean_reg;
    assign variance_scaled = out_var_reg;
    assign overflowed      = out_drop_reg;

    always_comb
    begin
        state_next       = state_reg;
        q_pop            = 1'b0;
        max_next         = max_reg;
        max_idx_next     = max_idx_reg;
        min_next         = min_reg;
        min_idx_next     = min_idx_reg;
        n_next           = n_reg;
        sq_next          = sq_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        drop_next        = drop_reg;
        step_next        = step_reg + STEPW'(1);
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        prod_next        = prod_reg;
        dvar_next        = dvar_reg;
        dvd_next         = dvd_reg;
        dsr_next         = dsr_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        mean_next        = mean_reg;
        ov_next          = ov_reg && !pop;
        out_max_next     = out_max_reg;
        out_max_idx_next = out_max_idx_reg;
        out_min_next     = out_min_reg;
        out_min_idx_next = out_min_idx_reg;
        out_n_next       = out_n_reg;
        out_mean_next    = out_mean_reg;
        out_var_next     = out_var_reg;
        out_drop_next    = out_drop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (!q_stat.empty)
                begin
                    q_pop        = 1'b1;
                    max_next     = rec_max;
                    max_idx_next = rec_max_idx;
                    min_next     = rec_min;
                    min_idx_next = rec_min_idx;
                    n_next       = rec_count;
                    sq_next      = rec_sq;
                    mag_next     = sum_abs[MAGW-1:0];
                    neg_next     = rec_sum[SUMW-1];
                    drop_next    = rec_drop;
                    // Mean: |sum| * 2^F / n.
                    dvd_next     = DVW'(sum_abs[MAGW-1:0]) << F;
                    dsr_next     = DSW'(rec_count);
                    rem_next     = '0;
                    quo_next     = '0;
                    state_next   = ST_DIV_M;
                end
            end

            ST_DIV_M:
            begin
                rem_next = rem_s;
                quo_next = quo_s;
                dvd_next = dvd_reg << 1;
                if (step_reg == STEPW'(DVW - 1))
                begin
                    mean_next   = neg_reg ? MEANW'(0) - quo_s[MEANW-1:0] : quo_s[MEANW-1:0];
                    // Next: n * sum of squares.
                    mcand_next  = PW'(sq_reg);
                    mplier_next = MAGW'(n_reg);
                    prod_next   = '0;
                    step_next   = '0;
                    state_next  = ST_MUL_A;
                end
            end

            ST_MUL_A:
            begin
                prod_next   = prod_s;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (step_reg == STEPW'(NW - 1))
                begin
                    dvar_next   = prod_s;
                    // Next: sum squared.
                    mcand_next  = PW'(mag_reg);
                    mplier_next = mag_reg;
                    prod_next   = '0;
                    step_next   = '0;
                    state_next  = ST_MUL_B;
                end
            end

            ST_MUL_B:
            begin
                prod_next   = prod_s;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (step_reg == STEPW'(MAGW - 1))
                begin
                    dvar_next   = dvar_reg - prod_s;
                    // Next: n squared, the variance divisor.
                    mcand_next  = PW'(n_reg);
                    mplier_next = MAGW'(n_reg);
                    prod_next   = '0;
                    step_next   = '0;
                    state_next  = ST_MUL_C;
                end
            end

            ST_MUL_C:
            begin
                prod_next   = prod_s;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (step_reg == STEPW'(NW - 1))
                begin
                    dsr_next   = prod_s[DSW-1:0];
                    dvd_next   = DVW'(dvar_reg) << F;
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV_V;
                end
            end

            ST_DIV_V:
            begin
                rem_next = rem_s;
                quo_next = quo_s;
                dvd_next = dvd_reg << 1;
                if (step_reg == STEPW'(DVW - 1))
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                step_next = '0;
                if (!ov_reg || pop)
                begin
                    ov_next          = 1'b1;
                    out_max_next     = max_reg;
                    out_max_idx_next = max_idx_reg;
                    out_min_next     = min_reg;
                    out_min_idx_next = min_idx_reg;
                    out_n_next       = n_reg;
                    out_mean_next    = mean_reg;
                    out_var_next     = quo_reg[VARW-1:0];
                    out_drop_next    = drop_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg         <= max_next;
        max_idx_reg     <= max_idx_next;
        min_reg         <= min_next;
        min_idx_reg     <= min_idx_next;
        n_reg           <= n_next;
        sq_reg          <= sq_next;
        mag_reg         <= mag_next;
        neg_reg         <= neg_next;
        drop_reg        <= drop_next;
        mcand_reg       <= mcand_next;
        mplier_reg      <= mplier_next;
        prod_reg        <= prod_next;
        dvar_reg        <= dvar_next;
        dvd_reg         <= dvd_next;
        dsr_reg         <= dsr_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        mean_reg        <= mean_next;
        out_max_reg     <= out_max_next;
        out_max_idx_reg <= out_max_idx_next;
        out_min_reg     <= out_min_next;
        out_min_idx_reg <= out_min_idx_next;
        out_n_reg       <= out_n_next;
        out_mean_reg    <= out_mean_next;
        out_var_reg     <= out_var_next;
        out_drop_reg    <= out_drop_next;
    end

    `SMMV_ASSERT_NOW(a_pop_idle, q_pop, (state_reg == ST_IDLE) && !q_stat.empty,
        "record taken from the queue outside the idle state")
    `SMMV_ASSERT_NEXT(a_start_div, (state_reg == ST_IDLE) && !q_stat.empty,
        state_reg == ST_DIV_M, "record taken but mean division did not start")
    `SMMV_ASSERT_NOW(a_rem_bound, (state_reg == ST_DIV_M) || (state_reg == ST_DIV_V),
        rem_reg < REMW'(dsr_reg), "divider remainder not below the divisor")

endmodule

// ----- rtl/stream_min_max_mean_variance_core.sv -----
// Top level of the stream statistics core: accumulator, record queue, arithmetic unit.
// Depends on smmv_pkg, smmv_front, smmv_queue and smmv_back.
//
// Usage. Samples enter through a queue-like port: a transfer happens on a rising edge
// with push high and full low. Each sample is folded into a running count, sum, sum of
// squares, maximum and minimum (ties keep the earlier position) in the cycle it is
// transferred, so ordinary samples stream in at one per cycle while full is low. A
// sample with last set closes the set: its record moves into a two-entry queue and the
// accumulator clears. Samples past 2^COUNT_BITS in one set are dropped and the
// result's overflowed flag set. Results leave through a queue-like port: while empty
// is low the result fields hold the oldest result, and a transfer happens on a rising
// edge with pop high. The arithmetic unit uses a bit-serial shared divider (mean,
// then variance) and a shift-add multiplier that forms n*sumsq, sum^2 and n^2, one
// bit per cycle. A new set can stream in while the previous one is worked on; full
// rises only when two finished records already wait. If the receiver stalls, the
// result is held and the pipeline fills up behind it. Reset clears the accumulator,
// queue and result valid.
module stream_min_max_mean_variance_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic signed [SAMPLE_BITS-1:0]           sample,
    input  logic                                    last,
    output logic                                    empty,
    input  logic                                    pop,
    output logic signed [SAMPLE_BITS-1:0]           max_value,
    output logic [COUNT_BITS-1:0]                   max_index,
    output logic signed [SAMPLE_BITS-1:0]           min_value,
    output logic [COUNT_BITS-1:0]                   min_index,
    output logic [COUNT_BITS:0]                     sample_count,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] mean_scaled,
    output logic [2*SAMPLE_BITS+FRAC_BITS-2:0]      variance_scaled,
    output logic                                    overflowed
);
    import smmv_pkg::*;

    localparam int SW    = SAMPLE_BITS;
    localparam int CW    = COUNT_BITS;
    localparam int NW    = CW + 1;
    localparam int SUMW  = SW + CW + 1;
    localparam int SQW   = 2 * SW + CW + 1;
    localparam int REC_W = 2 * SW + 2 * CW + NW + SUMW + SQW + 1;

    qstat_t q_stat;
    logic   q_push;
    logic   q_pop;

    // Record written by the front end.
    logic signed [SW-1:0]   f_max;
    logic [CW-1:0]          f_max_idx;
    logic signed [SW-1:0]   f_min;
    logic [CW-1:0]          f_min_idx;
    logic [NW-1:0]          f_count;
    logic signed [SUMW-1:0] f_sum;
    logic [SQW-1:0]         f_sq;
    logic                   f_drop;

    // Record at the head of the queue.
    logic signed [SW-1:0]   b_max;
    logic [CW-1:0]          b_max_idx;
    logic signed [SW-1:0]   b_min;
    logic [CW-1:0]          b_min_idx;
    logic [NW-1:0]          b_count;
    logic signed [SUMW-1:0] b_sum;
    logic [SQW-1:0]         b_sq;
    logic                   b_drop;

    logic [REC_W-1:0] q_wdata;
    logic [REC_W-1:0] q_rdata;

    assign q_wdata = {f_max, f_max_idx, f_min, f_min_idx, f_count, f_sum, f_sq, f_drop};
    assign {b_max, b_max_idx, b_min, b_min_idx, b_count, b_sum, b_sq, b_drop} = q_rdata;

    smmv_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample      (sample),
        .last        (last),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .rec_max     (f_max),
        .rec_max_idx (f_max_idx),
        .rec_min     (f_min),
        .rec_min_idx (f_min_idx),
        .rec_count   (f_count),
        .rec_sum     (f_sum),
        .rec_sq      (f_sq),
        .rec_drop    (f_drop)
    );

    smmv_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    smmv_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_stat          (q_stat),
        .q_pop           (q_pop),
        .rec_max         (b_max),
        .rec_max_idx     (b_max_idx),
        .rec_min         (b_min),
        .rec_min_idx     (b_min_idx),
        .rec_count       (b_count),
        .rec_sum         (b_sum),
        .rec_sq          (b_sq),
        .rec_drop        (b_drop),
        .empty           (empty),
        .pop             (pop),
        .max_value       (max_value),
        .max_index       (max_index),
        .min_value       (min_value),
        .min_index       (min_index),
        .sample_count    (sample_count),
        .mean_scaled     (mean_scaled),
        .variance_scaled (variance_scaled),
        .overflowed      (overflowed)
    );

endmodule
